>>> src/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants of the shortest-seek-first disk request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int REQUESTERS_DEF  = 8;
  localparam int TRACK_WIDTH_DEF = 10;

  localparam int ID_W     = 3;
  localparam int CFG_W    = 4;
  localparam int STATUS_W = 3;
  localparam int QCOUNT_W = 4;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [CFG_W-1:0] QUEUE_LIMIT_RST    = 4'd3;
  localparam logic [CFG_W-1:0] NUM_REQUESTERS_RST = 4'd5;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_RETIRE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_FULL            = 3'd1,
    ST_PENDING         = 3'd2,
    ST_RETIRE_PENDING  = 3'd3,
    ST_RETIRED         = 3'd4
  } status_t;

  typedef enum logic {
    REG_QUEUE_LIMIT    = 1'b0,
    REG_NUM_REQUESTERS = 1'b1
  } reg_idx_t;

endpackage

>>> src/sstf_if.sv
// ----------------------------------------------------------------------------
// sstf_req_if / sstf_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface sstf_req_if import sstf_pkg::*; #(
  parameter int TRACK_WIDTH = TRACK_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [ID_W-1:0]        requester_id;
  logic [TRACK_WIDTH-1:0] track;

  modport source (output valid, operation, requester_id, track, input ready);
  modport sink   (input valid, operation, requester_id, track, output ready);
endinterface

interface sstf_rsp_if import sstf_pkg::*; #(
  parameter int TRACK_WIDTH = TRACK_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic                   served_valid;
  logic [ID_W-1:0]        served_requester;
  logic [TRACK_WIDTH-1:0] served_track;
  logic [QCOUNT_W-1:0]    queue_count;
  logic                   all_done;

  modport source (output valid, status, served_valid, served_requester, served_track,
                  queue_count, all_done, input ready);
  modport sink   (input valid, status, served_valid, served_requester, served_track,
                  queue_count, all_done, output ready);
endinterface

>>> src/sstf_disk_request_scheduler.sv
// Flow: an accepted request word goes through S_CHECK, then S_SCAN and S_SHIFT when a word
// is served, and then S_RESP, which loads the result register once the result side is free.
// Only one word is in flight; the next request word is taken the cycle after the result
// register loads, so a stalled result side holds back the next request word.
// Reset (synchronous): queue, marks, counts and head cleared, registers back to 3 and 5.
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Shortest-seek-first disk request scheduler with an arrival-ordered queue kept in
// an entry memory, per-requester pending and retired marks, and an APB register port.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int REQUESTERS  = REQUESTERS_DEF,
  parameter int TRACK_WIDTH = TRACK_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  sstf_req_if.sink          req,
  sstf_rsp_if.source        rsp
);

  localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int RW  = $clog2(REQUESTERS + 1);
  localparam int RIW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int EW  = ID_W + TRACK_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                 state;
  logic [CFG_W-1:0]       queue_limit;
  logic [CFG_W-1:0]       num_requesters;
  logic [CW-1:0]          count;
  logic [REQUESTERS-1:0]  pending;
  logic [REQUESTERS-1:0]  retired;
  logic [RW-1:0]          retired_count;
  logic [TRACK_WIDTH-1:0] head_track;
  status_t                status_r;
  logic                   serve;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          rd_idx;
  logic                   rd_vld;
  logic [CW-1:0]          best_idx;
  logic [TRACK_WIDTH-1:0] best_dist;
  logic [TRACK_WIDTH-1:0] best_track;
  logic [ID_W-1:0]        best_req;

  logic                   rsp_valid;
  status_t                rsp_status;
  logic                   rsp_served_valid;
  logic [ID_W-1:0]        rsp_served_requester;
  logic [TRACK_WIDTH-1:0] rsp_served_track;
  logic [QCOUNT_W-1:0]    rsp_queue_count;
  logic                   rsp_all_done;

  logic                   cfg_we;
  reg_idx_t               cfg_idx;
  logic [CW-1:0]          cap;
  logic [RW-1:0]          taking;
  logic [RW-1:0]          active;
  int                     thr;
  logic                   serve_hit;
  logic                   req_fire;
  logic [RIW-1:0]         id_idx;
  logic                   id_out;
  status_t                st;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [TRACK_WIDTH-1:0] rd_track;
  logic [ID_W-1:0]        rd_req;
  logic [TRACK_WIDTH-1:0] seek_dist;
  logic                   take;
  logic                   rsp_load;
  logic [CW-1:0]          count_after;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_QUEUE_LIMIT:    prdata = APB_DW'(queue_limit);
      REG_NUM_REQUESTERS: prdata = APB_DW'(num_requesters);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit    <= QUEUE_LIMIT_RST;
      num_requesters <= NUM_REQUESTERS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_QUEUE_LIMIT:    queue_limit <= pwdata[CFG_W-1:0];
        REG_NUM_REQUESTERS: num_requesters <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped capacity, requesters taking part and the service threshold.
  always_comb begin
    if (queue_limit == '0) begin
      cap = CW'(1);
    end else if (int'(queue_limit) > QUEUE_DEPTH) begin
      cap = CW'(QUEUE_DEPTH);
    end else begin
      cap = CW'(queue_limit);
    end
    if (int'(num_requesters) > REQUESTERS) begin
      taking = RW'(REQUESTERS);
    end else begin
      taking = RW'(num_requesters);
    end
    active    = (retired_count >= taking) ? '0 : taking - retired_count;
    thr       = (int'(active) < int'(cap)) ? int'(active) : int'(cap);
    serve_hit = (count != '0) && (int'(count) >= thr);
  end

  // Admission checks.
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign id_idx    = RIW'(req.requester_id);
  assign id_out    = int'(req.requester_id) >= int'(taking);

  always_comb begin
    if (id_out || retired[id_idx]) begin
      st = ST_RETIRED;
    end else if (req.operation == OP_SUBMIT) begin
      if (pending[id_idx]) begin
        st = ST_PENDING;
      end else if (count >= cap) begin
        st = ST_FULL;
      end else begin
        st = ST_OK;
      end
    end else begin
      st = pending[id_idx] ? ST_RETIRE_PENDING : ST_OK;
    end
  end

  // Entry memory: appends on submit, compaction writes while shifting.
  assign rd_track  = ram_rdata[TRACK_WIDTH-1:0];
  assign rd_req    = ram_rdata[TRACK_WIDTH +: ID_W];
  assign seek_dist = (rd_track >= head_track) ? rd_track - head_track
                                              : head_track - rd_track;
  assign take      = rd_vld && ((rd_idx == '0) || (seek_dist < best_dist));
  assign ram_raddr = AW'(idx);

  always_comb begin
    if (state == S_SHIFT) begin
      ram_we    = rd_vld;
      ram_waddr = AW'(rd_idx - CW'(1));
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = req_fire && (st == ST_OK) && (req.operation == OP_SUBMIT);
      ram_waddr = AW'(count);
      ram_wdata = {req.requester_id, req.track};
    end
  end

  sstf_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rsp_load    = (state == S_RESP) && (!rsp_valid || rsp.ready);
  assign count_after = serve ? count - CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      pending       <= '0;
      retired       <= '0;
      retired_count <= '0;
      head_track    <= '0;
      rd_vld        <= 1'b0;
      idx           <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            status_r <= st;
            if (st == ST_OK) begin
              if (req.operation == OP_SUBMIT) begin
                count           <= count + CW'(1);
                pending[id_idx] <= 1'b1;
              end else begin
                retired[id_idx] <= 1'b1;
                retired_count   <= retired_count + RW'(1);
              end
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          serve  <= serve_hit;
          idx    <= '0;
          rd_vld <= 1'b0;
          state  <= serve_hit ? S_SCAN : S_RESP;
        end
        S_SCAN: begin
          if (idx < count) begin
            rd_vld <= 1'b1;
            rd_idx <= idx;
            idx    <= idx + CW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (take) begin
            best_idx   <= rd_idx;
            best_dist  <= seek_dist;
            best_track <= rd_track;
            best_req   <= rd_req;
          end
          if (rd_vld && (rd_idx == count - CW'(1))) begin
            idx   <= (take ? rd_idx : best_idx) + CW'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (idx < count) begin
            rd_vld <= 1'b1;
            rd_idx <= idx;
            idx    <= idx + CW'(1);
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (rsp_load) begin
            if (serve) begin
              count                  <= count_after;
              head_track             <= best_track;
              pending[RIW'(best_req)] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status           <= status_r;
      rsp_served_valid     <= serve;
      rsp_served_requester <= serve ? best_req : '0;
      rsp_served_track     <= serve ? best_track : '0;
      rsp_queue_count      <= QCOUNT_W'(count_after);
      rsp_all_done         <= (active == '0) && (count_after == '0);
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.status           = rsp_status;
  assign rsp.served_valid     = rsp_served_valid;
  assign rsp.served_requester = rsp_served_requester;
  assign rsp.served_track     = rsp_served_track;
  assign rsp.queue_count      = rsp_queue_count;
  assign rsp.all_done         = rsp_all_done;

`ifndef NO_ASSERTIONS
  a_pending_matches_queue: assert property (@(posedge clk) disable iff (rst)
    $countones(pending) == int'(count))
    else $error("pending marks disagree with queue fill");

  a_retired_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(retired) == int'(retired_count))
    else $error("retired marks disagree with retired count");

  a_queue_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_DEPTH)
    else $error("queue fill beyond memory depth");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE || state == S_SHIFT))
    else $error("entry memory written during scan");

  a_head_follows_serve: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && serve) |=> (head_track == rsp_served_track))
    else $error("head track not moved to served track");
`endif

endmodule

>>> src/sstf_ram.sv
// ----------------------------------------------------------------------------
// sstf_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sstf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> test/sstf_disk_request_scheduler_test.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_test
// Self-checking testbench for the shortest-seek-first disk request scheduler.
// A short table of directed words opens the run. Random phases follow, each under
// its own register setting, with bursty request traffic and a stalling result
// side. Each accepted result word is checked against the table's expected word,
// if any, else an in-bench model of the queue, pending and retired marks, head.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sstf_pkg::*;

  localparam int TW            = TRACK_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_WORDS   = 100;
  localparam int LAST_WORDS    = 200;

  typedef struct {
    status_t             status;
    logic                served_valid;
    logic [ID_W-1:0]     served_requester;
    logic [TW-1:0]       served_track;
    logic [QCOUNT_W-1:0] queue_count;
    logic                all_done;
  } outcome_t;

  typedef struct {
    logic             is_cfg;
    reg_idx_t         idx;
    logic [CFG_W-1:0] val;
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [TW-1:0]    trk;
    logic             known;
    outcome_t         want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sstf_req_if #(.TRACK_WIDTH(TW)) request_bus ();
  sstf_rsp_if #(.TRACK_WIDTH(TW)) result_bus ();

  sstf_disk_request_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (request_bus),
    .rsp     (result_bus)
  );

  always #5ns clk = ~clk;

  logic [TW-1:0]             lane_track [QUEUE_DEPTH_DEF];
  logic [ID_W-1:0]           lane_req   [QUEUE_DEPTH_DEF];
  int                        lane_count = 0;
  logic [REQUESTERS_DEF-1:0] waiting    = '0;
  logic [REQUESTERS_DEF-1:0] gone       = '0;
  int                        gone_count = 0;
  logic [TW-1:0]             head       = '0;
  logic [CFG_W-1:0]          cap_reg    = QUEUE_LIMIT_RST;
  logic [CFG_W-1:0]          part_reg   = NUM_REQUESTERS_RST;

  outcome_t    outcome_queue [$];
  outcome_t    no_outcome;
  plan_row_t   opening [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic [8:0]  stall_tick  = '0;

  logic [CFG_W-1:0] phase_cap [10] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd4, 4'd2, 4'd7,
                                       4'd6, 4'd3};
  logic [CFG_W-1:0] phase_req [10] = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd8, 4'd6, 4'd15,
                                       4'd8, 4'd8};

  function automatic int capacity_now();
    if (cap_reg == 0) return 1;
    if (cap_reg > QUEUE_DEPTH_DEF) return QUEUE_DEPTH_DEF;
    return int'(cap_reg);
  endfunction

  function automatic int taking_part_now();
    return (part_reg > REQUESTERS_DEF) ? REQUESTERS_DEF : int'(part_reg);
  endfunction

  function automatic int active_now();
    return (gone_count >= taking_part_now()) ? 0 : taking_part_now() - gone_count;
  endfunction

  function automatic logic [REQUESTERS_DEF-1:0] part_mask();
    logic [REQUESTERS_DEF-1:0] m;
    m = '0;
    for (int i = 0; i < taking_part_now(); i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic logic [REQUESTERS_DEF-1:0] free_mask();
    return part_mask() & ~waiting & ~gone;
  endfunction

  function automatic logic [ID_W-1:0] pick_from(input logic [REQUESTERS_DEF-1:0] m);
    int k;
    logic [ID_W-1:0] id;
    k = $urandom_range(0, $countones(m) - 1);
    id = '0;
    for (int i = 0; i < REQUESTERS_DEF; i++) begin
      if (m[i]) begin
        if (k == 0) id = ID_W'(i);
        k--;
      end
    end
    return id;
  endfunction

  // Applies one word to the model state and returns the result word it causes.
  function automatic outcome_t sstf_decide(input op_t op, input logic [ID_W-1:0] id,
                                           input logic [TW-1:0] trk);
    outcome_t o;
    int trigger;
    int best;
    int best_d;
    int d;
    o.status = ST_OK;
    o.served_valid = 1'b0;
    o.served_requester = '0;
    o.served_track = '0;
    if (id >= taking_part_now() || gone[id]) begin
      o.status = ST_RETIRED;
    end else if (op == OP_SUBMIT) begin
      if (waiting[id]) begin
        o.status = ST_PENDING;
      end else if (lane_count >= capacity_now()) begin
        o.status = ST_FULL;
      end else begin
        lane_track[lane_count] = trk;
        lane_req[lane_count] = id;
        lane_count++;
        waiting[id] = 1'b1;
      end
    end else if (waiting[id]) begin
      o.status = ST_RETIRE_PENDING;
    end else begin
      gone[id] = 1'b1;
      gone_count++;
    end
    trigger = active_now();
    if (capacity_now() < trigger) trigger = capacity_now();
    if (lane_count > 0 && lane_count >= trigger) begin
      best = 0;
      best_d = 0;
      for (int i = 0; i < lane_count; i++) begin
        d = int'(lane_track[i]) - int'(head);
        if (d < 0) d = -d;
        if (i == 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      o.served_valid = 1'b1;
      o.served_track = lane_track[best];
      o.served_requester = lane_req[best];
      head = lane_track[best];
      waiting[lane_req[best]] = 1'b0;
      for (int i = best; i + 1 < lane_count; i++) begin
        lane_track[i] = lane_track[i + 1];
        lane_req[i] = lane_req[i + 1];
      end
      lane_count--;
    end
    o.queue_count = QCOUNT_W'(lane_count);
    o.all_done = (active_now() == 0 && lane_count == 0);
    return o;
  endfunction

  function automatic plan_row_t word_row(input op_t op, input logic [ID_W-1:0] id,
                                         input logic [TW-1:0] trk);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_QUEUE_LIMIT;
    r.val = '0;
    r.op = op;
    r.id = id;
    r.trk = trk;
    r.known = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t known_row(input op_t op, input logic [ID_W-1:0] id,
                                          input logic [TW-1:0] trk, input status_t st,
                                          input logic sv, input logic [ID_W-1:0] sreq,
                                          input logic [TW-1:0] strk,
                                          input logic [QCOUNT_W-1:0] qc, input logic dn);
    plan_row_t r;
    r = word_row(op, id, trk);
    r.known = 1'b1;
    r.want.status = st;
    r.want.served_valid = sv;
    r.want.served_requester = sreq;
    r.want.served_track = strk;
    r.want.queue_count = qc;
    r.want.all_done = dn;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    plan_row_t r;
    r = word_row(OP_SUBMIT, '0, '0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  task automatic add_row(input plan_row_t r);
    opening.insert(opening.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_word(input op_t op, input logic [ID_W-1:0] id,
                           input logic [TW-1:0] trk, input logic known,
                           input outcome_t want);
    outcome_t o;
    request_bus.valid <= 1'b1;
    request_bus.operation <= op;
    request_bus.requester_id <= id;
    request_bus.track <= trk;
    do @(posedge clk); while (!request_bus.ready);
    o = sstf_decide(op, id, trk);
    outcome_queue.insert(outcome_queue.size(), known ? want : o);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      request_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    request_bus.valid <= 1'b0;
    do @(posedge clk); while (outcome_queue.size() != 0);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(APB_DW - CFG_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_QUEUE_LIMIT) cap_reg = val;
    else part_reg = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", 32'(val), 32'(prdata[CFG_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[8:7])
      2'd0: result_bus.ready <= 1'b1;
      2'd1: result_bus.ready <= 1'($urandom_range(0, 1));
      2'd2: result_bus.ready <= ($urandom_range(0, 4) == 0);
      default: result_bus.ready <= (stall_tick[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (outcome_queue.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
      end else begin
        w = outcome_queue.pop_front();
        check_field("status", 32'(w.status), 32'(result_bus.status));
        check_field("served_valid", 32'(w.served_valid), 32'(result_bus.served_valid));
        check_field("served_requester", 32'(w.served_requester),
                    32'(result_bus.served_requester));
        check_field("served_track", 32'(w.served_track), 32'(result_bus.served_track));
        check_field("queue_count", 32'(w.queue_count), 32'(result_bus.queue_count));
        check_field("all_done", 32'(w.all_done), 32'(result_bus.all_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int burst_left;
    int roll;
    int d;
    int words;
    op_t op;
    logic [ID_W-1:0] id;
    logic [TW-1:0] trk;
    logic [REQUESTERS_DEF-1:0] mask;
    logic [CFG_W-1:0] cap_v;
    logic [CFG_W-1:0] req_v;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    request_bus.valid <= 1'b0;
    request_bus.operation <= OP_SUBMIT;
    request_bus.requester_id <= '0;
    request_bus.track <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_row(known_row(OP_SUBMIT, 0, 0, ST_OK, 0, 0, 0, 1, 0));
    add_row(known_row(OP_SUBMIT, 0, 5, ST_PENDING, 0, 0, 0, 1, 0));
    add_row(known_row(OP_SUBMIT, 7, 1023, ST_RETIRED, 0, 0, 0, 1, 0));
    add_row(known_row(OP_RETIRE, 0, 0, ST_RETIRE_PENDING, 0, 0, 0, 1, 0));
    add_row(known_row(OP_RETIRE, 4, 1023, ST_OK, 0, 0, 0, 1, 0));
    add_row(known_row(OP_SUBMIT, 4, 9, ST_RETIRED, 0, 0, 0, 1, 0));
    add_row(known_row(OP_RETIRE, 4, 0, ST_RETIRED, 0, 0, 0, 1, 0));
    add_row(known_row(OP_SUBMIT, 1, 1023, ST_OK, 0, 0, 0, 2, 0));
    add_row(known_row(OP_SUBMIT, 2, 512, ST_OK, 1, 0, 0, 2, 0));
    add_row(word_row(OP_SUBMIT, 3, 1023));
    add_row(word_row(OP_SUBMIT, 0, 0));
    add_row(word_row(OP_SUBMIT, 2, 1023));
    add_row(word_row(OP_SUBMIT, 1, 682));
    add_row(reg_row(REG_QUEUE_LIMIT, 8));
    add_row(reg_row(REG_NUM_REQUESTERS, 8));
    add_row(word_row(OP_SUBMIT, 5, 1023));
    add_row(word_row(OP_SUBMIT, 6, 0));
    add_row(word_row(OP_SUBMIT, 7, 341));
    add_row(reg_row(REG_QUEUE_LIMIT, 1));
    add_row(word_row(OP_SUBMIT, 5, 100));
    add_row(word_row(OP_SUBMIT, 3, 200));
    add_row(reg_row(REG_QUEUE_LIMIT, 0));
    add_row(word_row(OP_SUBMIT, 6, 1023));
    add_row(reg_row(REG_QUEUE_LIMIT, 15));
    add_row(reg_row(REG_NUM_REQUESTERS, 15));
    add_row(word_row(OP_SUBMIT, 7, 7));
    add_row(reg_row(REG_NUM_REQUESTERS, 0));
    add_row(word_row(OP_SUBMIT, 0, 7));
    add_row(word_row(OP_RETIRE, 1, 0));

    for (int k = 0; k < opening.size(); k++) begin
      if (opening[k].is_cfg) begin
        write_register(opening[k].idx, opening[k].val);
      end else begin
        send_word(opening[k].op, opening[k].id, opening[k].trk, opening[k].known,
                  opening[k].want);
        pause_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      end
    end

    // The last phase retires requesters for good, so earlier phases only send
    // retire words that are refused.
    for (int p = 0; p < 12; p++) begin
      if (p < 10) begin
        cap_v = phase_cap[p];
        req_v = phase_req[p];
      end else if (p == 10) begin
        cap_v = CFG_W'($urandom_range(0, 15));
        req_v = CFG_W'($urandom_range(0, 15));
      end else begin
        cap_v = CFG_W'($urandom_range(1, 8));
        req_v = CFG_W'(REQUESTERS_DEF);
      end
      write_register(REG_QUEUE_LIMIT, cap_v);
      write_register(REG_NUM_REQUESTERS, req_v);
      words = (p == 11) ? LAST_WORDS : PHASE_WORDS;
      burst_left = 0;
      for (int k = 0; k < words; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 29) == 0) wait_drained();
          else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        op = OP_SUBMIT;
        mask = free_mask();
        if (p == 11 && roll < 35) begin
          op = OP_RETIRE;
          id = (mask != 0) ? pick_from(mask) : ID_W'($urandom_range(0, 7));
        end else if (roll < 8) begin
          mask = waiting | gone | ~part_mask();
          if (mask != 0) begin
            op = OP_RETIRE;
            id = pick_from(mask);
          end else begin
            id = ID_W'($urandom_range(0, 7));
          end
        end else if (roll < 20 || mask == 0) begin
          id = ID_W'($urandom_range(0, 7));
        end else begin
          id = pick_from(mask);
        end
        case ($urandom_range(0, 3))
          0: trk = $urandom_range(0, 1) ? '1 : '0;
          1: begin
            d = $urandom_range(0, 3);
            if (($urandom_range(0, 1) && int'(head) >= d) || int'(head) + d > 1023)
              trk = TW'(int'(head) - d);
            else
              trk = TW'(int'(head) + d);
          end
          default: trk = TW'($urandom_range(0, 1023));
        endcase
        send_word(op, id, trk, 1'b0, no_outcome);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
